### rtl/quadrature_dual_counter_registers_core_defines.svh
// Assertion macros for the RTL of the quadrature counter block.
// The asserting module provides clk_i and rst_ni.
`ifndef QUADRATURE_DUAL_COUNTER_REGISTERS_CORE_DEFINES_SVH
`define QUADRATURE_DUAL_COUNTER_REGISTERS_CORE_DEFINES_SVH

// Same-cycle implication
`define QDCR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication
`define QDCR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

### rtl/qdcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qdcr_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned HistW = 2;

  // Bus command codes
  localparam logic [7:0] CMD_RESET      = 8'd1;
  localparam logic [7:0] CMD_CENTER     = 8'd2;
  localparam logic [7:0] CMD_READ_POS   = 8'd10;
  localparam logic [7:0] CMD_READ_DELTA = 8'd11;

  localparam logic [CntW-1:0] CENTER_VALUE = 16'd32767;
  localparam logic [HistW-1:0] HIST_RESET  = 2'd3;

  // Input word, packed as on the slave tdata (highest field first)
  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] channel;
    logic [7:0] command;
    logic       switch_high;
    logic [1:0] encoder_ab;
  } in_word_t;

  // Quadrature transition table: index {old_ab, new_ab}, two's complement step
  function automatic logic [CntW-1:0] step_lookup(input logic [3:0] idx);
    logic [CntW-1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: step = '1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 16'd1;
      default:                  step = '0;
    endcase
    return step;
  endfunction

endpackage

`default_nettype wire

### rtl/quadrature_dual_counter_registers_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "quadrature_dual_counter_registers_core_defines.svh"

// Two-bank quadrature encoder counter with a small command port. Each input
// word is either a pin event (tuser = 0) or a bus command (tuser = 1). One
// word is accepted per clock unless the slave side stalls; a word is held in
// an input register and applied to the counters from there, and a read
// result is then held in the output register until the master side takes it.
// The slave side stalls only while the input register holds a read command
// and the output register still holds an untaken result.
module quadrature_dual_counter_registers_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: [1:0] encoder_ab, [2] switch_high, [10:3] command, [18:11] channel,
  //        [23:19] zero fill
  input  wire logic [23:0] s_axis_tdata,
  // tuser: [0] mode
  input  wire logic        s_axis_tuser,
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: [15:0] read_data
  output logic [15:0]      m_axis_tdata
);

  localparam int unsigned CntW  = qdcr_pkg::CntW;
  localparam int unsigned HistW = qdcr_pkg::HistW;

  // Input register
  logic               in_valid_q, in_valid_d;
  logic               in_mode_q;
  qdcr_pkg::in_word_t in_word_q;

  // Counter state
  logic [HistW-1:0] hist_q [2];
  logic [HistW-1:0] hist_d [2];
  logic [CntW-1:0]  pos_q  [2];
  logic [CntW-1:0]  pos_d  [2];
  logic [CntW-1:0]  delta_q [2];
  logic [CntW-1:0]  delta_d [2];

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] out_data_q, out_data_d;

  logic            is_read;
  logic            out_free;
  logic            fire;
  logic            s_fire;
  logic            bank;
  logic [3:0]      step_idx;
  logic [CntW-1:0] step;

  // Bank and read decode for the word in the input register
  assign bank = in_mode_q ? (in_word_q.channel != 8'd0) : ~in_word_q.switch_high;
  assign is_read = in_mode_q && ((in_word_q.command == qdcr_pkg::CMD_READ_POS) ||
                                 (in_word_q.command == qdcr_pkg::CMD_READ_DELTA));
  assign out_free = !out_valid_q || m_axis_tready;
  assign fire     = in_valid_q && (!is_read || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign step_idx = {hist_q[bank], in_word_q.encoder_ab};
  assign step     = qdcr_pkg::step_lookup(step_idx);

  // Counter update and result
  always_comb begin
    hist_d      = hist_q;
    pos_d       = pos_q;
    delta_d     = delta_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (fire) begin
      if (!in_mode_q) begin
        hist_d[bank]  = in_word_q.encoder_ab;
        pos_d[bank]   = pos_q[bank] + step;
        delta_d[bank] = delta_q[bank] + step;
      end else begin
        unique case (in_word_q.command)
          qdcr_pkg::CMD_RESET: begin
            pos_d[bank]   = '0;
            delta_d[bank] = '0;
          end
          qdcr_pkg::CMD_CENTER: begin
            pos_d[bank]   = qdcr_pkg::CENTER_VALUE;
            delta_d[bank] = '0;
          end
          qdcr_pkg::CMD_READ_POS: begin
            out_data_d  = pos_q[bank];
            out_valid_d = 1'b1;
          end
          qdcr_pkg::CMD_READ_DELTA: begin
            out_data_d    = delta_q[bank];
            out_valid_d   = 1'b1;
            delta_d[bank] = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign in_valid_d = s_fire || (in_valid_q && !fire);

  // Control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q[0]   <= qdcr_pkg::HIST_RESET;
      hist_q[1]   <= qdcr_pkg::HIST_RESET;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      delta_q[0]  <= '0;
      delta_q[1]  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      hist_q      <= hist_d;
      pos_q       <= pos_d;
      delta_q     <= delta_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_mode_q <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // New result only from an applied read command
  `QDCR_ASSERT_NXT(a_result_from_read, !(fire && is_read) && m_axis_tready, !m_axis_tvalid)
  // Read delta leaves the selected bank's delta at zero
  `QDCR_ASSERT_NXT(a_delta_clear_b0,
                   fire && in_mode_q && !bank && in_word_q.command == qdcr_pkg::CMD_READ_DELTA,
                   delta_q[0] == '0)
  `QDCR_ASSERT_NXT(a_delta_clear_b1,
                   fire && in_mode_q && bank && in_word_q.command == qdcr_pkg::CMD_READ_DELTA,
                   delta_q[1] == '0)
  // Stall only while a read waits on a full output register
  `QDCR_ASSERT_IMP(a_stall_reason, !s_axis_tready,
                   in_valid_q && is_read && out_valid_q && !m_axis_tready)

endmodule

`default_nettype wire
